>>> design/rgbpf_pkg.sv
// types, register codes and constants shared by the rgb pwm flicker ramp block
`default_nettype none
package rgbpf_pkg;

	// ramp phases
	typedef enum logic [1:0] {
		PH_SLOW_RISE = 2'd0,
		PH_SLOW_FALL = 2'd1,
		PH_FAST_RISE = 2'd2,
		PH_FAST_FALL = 2'd3
	} phase_t;

	// configuration register indexes
	localparam logic [1:0] CFG_RED_GAIN   = 2'd0;
	localparam logic [1:0] CFG_GREEN_GAIN = 2'd1;
	localparam logic [1:0] CFG_BLUE_GAIN  = 2'd2;
	localparam logic [1:0] CFG_FULL_COUNT = 2'd3;

	// configuration reset values
	localparam logic [8:0] RED_GAIN_RST   = 9'd128;
	localparam logic [8:0] GREEN_GAIN_RST = 9'd128;
	localparam logic [8:0] BLUE_GAIN_RST  = 9'd256;
	localparam logic [7:0] FULL_COUNT_RST = 8'd100;

	// ramp limits
	localparam logic [7:0] FAST_PEAK  = 8'd18;
	localparam logic [7:0] RAMP_FLOOR = 8'd6;

	// input transaction
	typedef struct packed {
		logic tick_fine;
		logic tick_fast;
		logic tick_slow;
	} in_t;

	// result transaction
	typedef struct packed {
		logic       red_on;
		logic       green_on;
		logic       blue_on;
		logic [7:0] brightness;
		logic [1:0] phase;
	} out_t;

	// configuration registers as seen by the datapath
	typedef struct packed {
		logic [8:0] red_gain;
		logic [8:0] green_gain;
		logic [8:0] blue_gain;
		logic [7:0] full_count;
	} cfg_t;

	// block state carried from tick to tick
	typedef struct packed {
		logic [7:0] pwm_count;
		logic [7:0] level;
		phase_t     phase;
		logic [2:0] led;
	} state_t;

endpackage
`default_nettype wire

>>> design/rgbpf_step.sv
// next-state logic for one tick: led compare, pwm counter and brightness ramp
`default_nettype none
module rgbpf_step (
	input  wire rgbpf_pkg::in_t    tick,
	input  wire rgbpf_pkg::cfg_t   cfg,
	input  wire rgbpf_pkg::state_t cur,
	output rgbpf_pkg::state_t      nxt
);

	logic [16:0] red_prod, green_prod, blue_prod;
	logic [7:0]  lvl_a, lvl_b;
	rgbpf_pkg::phase_t ph_a, ph_b;

	// colour levels from current brightness, full width kept
	assign red_prod   = {8'd0, cfg.red_gain}   * {9'd0, cur.level};
	assign green_prod = {8'd0, cfg.green_gain} * {9'd0, cur.level};
	assign blue_prod  = {8'd0, cfg.blue_gain}  * {9'd0, cur.level};

	// fine event: led drive and pwm counter; ramp result gathered here too
	always_comb begin
		nxt.led       = cur.led;
		nxt.pwm_count = cur.pwm_count;
		if (tick.tick_fine) begin
			nxt.led[0] = {1'b0, cur.pwm_count} < red_prod[16:8];
			nxt.led[1] = {1'b0, cur.pwm_count} < green_prod[16:8];
			nxt.led[2] = {1'b0, cur.pwm_count} < blue_prod[16:8];
			if (cur.pwm_count > cfg.full_count) begin
				nxt.pwm_count = 8'd0;
			end else begin
				nxt.pwm_count = cur.pwm_count + 8'd1;
			end
		end
		nxt.level = lvl_b;
		nxt.phase = ph_b;
	end

	// fast event: rise to the fast peak, then fall to the floor
	always_comb begin
		lvl_a = cur.level;
		ph_a  = cur.phase;
		if (tick.tick_fast) begin
			if (ph_a == rgbpf_pkg::PH_FAST_RISE) begin
				if (lvl_a < rgbpf_pkg::FAST_PEAK) begin
					lvl_a = lvl_a + 8'd1;
				end else begin
					ph_a = rgbpf_pkg::PH_FAST_FALL;
				end
			end
			if (ph_a == rgbpf_pkg::PH_FAST_FALL) begin
				if (lvl_a > rgbpf_pkg::RAMP_FLOOR) begin
					lvl_a = lvl_a - 8'd1;
				end else begin
					ph_a = rgbpf_pkg::PH_SLOW_RISE;
				end
			end
		end
	end

	// slow event: rise to full_count, then fall to the floor
	always_comb begin
		lvl_b = lvl_a;
		ph_b  = ph_a;
		if (tick.tick_slow) begin
			if (ph_b == rgbpf_pkg::PH_SLOW_RISE) begin
				if (lvl_b < cfg.full_count) begin
					lvl_b = lvl_b + 8'd1;
				end else begin
					ph_b = rgbpf_pkg::PH_SLOW_FALL;
				end
			end
			if (ph_b == rgbpf_pkg::PH_SLOW_FALL) begin
				if (lvl_b > rgbpf_pkg::RAMP_FLOOR) begin
					lvl_b = lvl_b - 8'd1;
				end else begin
					ph_b = rgbpf_pkg::PH_FAST_RISE;
				end
			end
		end
	end

endmodule
`default_nettype wire

>>> design/rgb_pwm_flicker_ramp_core.sv
// rgb pwm flicker ramp: input register, one-pass tick logic, result register
// a tick is held in the input register, passes through the tick logic and is captured in the result register
// throughput: one tick per cycle while the output is not stalled
// stall on the output backs up through the input register, which then raises in_stall
// reset: pwm counter, brightness and led drive at zero, ramp in slow rise,
// configuration registers at their documented defaults, both stages empty
`default_nettype none
module rgb_pwm_flicker_ramp_core (
	input  wire                  clk,
	input  wire                  arst_n,
	// tick channel
	input  wire                  in_valid,
	output logic                 in_stall,
	input  wire rgbpf_pkg::in_t  in_data,
	// result channel
	output logic                 out_valid,
	input  wire                  out_stall,
	output rgbpf_pkg::out_t      out_data,
	// configuration write channel
	input  wire                  cfg_valid,
	output logic                 cfg_ready,
	input  wire [1:0]            cfg_index,
	input  wire [8:0]            cfg_data
);

	logic              valid_s1;
	rgbpf_pkg::in_t    tick_s1;
	logic              out_valid_q;
	rgbpf_pkg::out_t   out_q;
	rgbpf_pkg::cfg_t   cfg_q;
	rgbpf_pkg::state_t state_q;
	rgbpf_pkg::state_t state_nxt;
	logic              advance;

	// configuration writes are always taken
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.red_gain   <= rgbpf_pkg::RED_GAIN_RST;
			cfg_q.green_gain <= rgbpf_pkg::GREEN_GAIN_RST;
			cfg_q.blue_gain  <= rgbpf_pkg::BLUE_GAIN_RST;
			cfg_q.full_count <= rgbpf_pkg::FULL_COUNT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				rgbpf_pkg::CFG_RED_GAIN:   cfg_q.red_gain   <= cfg_data;
				rgbpf_pkg::CFG_GREEN_GAIN: cfg_q.green_gain <= cfg_data;
				rgbpf_pkg::CFG_BLUE_GAIN:  cfg_q.blue_gain  <= cfg_data;
				rgbpf_pkg::CFG_FULL_COUNT: cfg_q.full_count <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	// stage 1 moves on when the result register is free or being emptied
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			tick_s1 <= in_data;
		end
	end

	// tick logic
	rgbpf_step u_step (
		.tick (tick_s1),
		.cfg  (cfg_q),
		.cur  (state_q),
		.nxt  (state_nxt)
	);

	// block state, updated once per transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.pwm_count <= 8'd0;
			state_q.level     <= 8'd0;
			state_q.phase     <= rgbpf_pkg::PH_SLOW_RISE;
			state_q.led       <= 3'd0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q.red_on     <= state_nxt.led[0];
			out_q.green_on   <= state_nxt.led[1];
			out_q.blue_on    <= state_nxt.led[2];
			out_q.brightness <= state_nxt.level;
			out_q.phase      <= state_nxt.phase;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
`default_nettype wire
